// File: rtl/impaired_frame_channel_unit_defines.svh
// assertion macros for the impaired frame channel
`ifndef IMPAIRED_FRAME_CHANNEL_UNIT_DEFINES_SVH
`define IMPAIRED_FRAME_CHANNEL_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define IFC_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define IFC_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define IFC_ASSERT_IMPL(label, clk, rst_n, prop)
`define IFC_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: rtl/ifc_pkg.sv
// shared types, constants and helpers of the impaired frame channel
`default_nettype none
package ifc_pkg;
    localparam int unsigned QueueDepthDefault = 16;
    localparam int unsigned MaxPayloadDefault = 8;

    typedef enum logic [1:0] {
        OP_PUBLISH = 2'd0,
        OP_INJECT  = 2'd1,
        OP_POLL    = 2'd2,
        OP_SETTIME = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_RANGE   = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_NOT_DUE = 3'd4,
        ST_DROPPED = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CFG_LOSS   = 2'd0,
        CFG_DELAY  = 2'd1,
        CFG_TAMPER = 2'd2,
        CFG_SEED   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DUE,
        BK_DRAW1,
        BK_MOD1,
        BK_DRAW2,
        BK_MOD2,
        BK_DONE
    } t_bk_state;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] frame_id;
        logic [3:0]  length_code;
        logic [63:0] payload;
        logic [47:0] time_ms;
        logic [31:0] seq_in;
        logic [7:0]  alive_in;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] out_id;
        logic [3:0]  out_length;
        logic [63:0] out_payload;
        logic [47:0] out_stamp;
        logic [31:0] out_seq;
        logic [7:0]  out_alive;
        logic        crc_invalid;
        logic [4:0]  fill_level;
    } t_rsp;

    function automatic logic [63:0] xorshift(input logic [63:0] s);
        logic [63:0] x;
        x = s ^ (s << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (len > 4'(i)) begin
                m[i*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction
endpackage
`default_nettype wire

// File: rtl/ifc_if.sv
// valid/ready channel interfaces for requests, results and configuration
`default_nettype none
interface ifc_req_if import ifc_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ifc_rsp_if import ifc_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ifc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// File: rtl/ifc_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module ifc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/ifc_front.sv
// front end: takes items and queues them for the back end
`default_nettype none
module ifc_front import ifc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ifc_req_if.sink   s_in,
    ifc_req_if.source m_q
);
    logic r_full;
    t_req r_data;

    assign s_in.ready = !r_full;
    assign m_q.valid  = r_full;
    assign m_q.data   = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (s_in.valid && !r_full) begin
            r_full <= 1'b1;
        end else if (m_q.ready) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in.valid && !r_full) begin
            r_data <= s_in.data;
        end
    end
endmodule
`default_nettype wire

// File: rtl/ifc_back.sv
// back end: frame queue, due check, loss and tamper draws
`default_nettype none
`include "impaired_frame_channel_unit_defines.svh"
module ifc_back import ifc_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
    parameter int unsigned MAX_PAYLOAD_BYTES = MaxPayloadDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ifc_req_if.sink   s_q,
    ifc_rsp_if.source m_out,
    ifc_cfg_if.sink   s_cfg
);
    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned FW = 32 + 4 + 64 + 48 + 32 + 8;

    t_bk_state r_state, n_state;
    logic [AW-1:0] r_rd, r_wr;
    logic [CW-1:0] r_held;
    logic [63:0]   r_gen, r_draw;
    logic [31:0]   r_nseq;
    logic [7:0]    r_nalive;
    logic [47:0]   r_now;
    logic [6:0]    r_loss;
    logic [31:0]   r_delay;
    logic          r_tamper;
    logic [6:0]    r_rem;
    logic [6:0]    r_cnt;
    logic [3:0]    r_lrem;
    logic [23:0]   r_acc;
    logic          r_ovalid;
    t_rsp          r_rsp;

    logic          we;
    logic [FW-1:0] wdata, rdata;
    logic [31:0]   h_id;
    logic [3:0]    h_len;
    logic [63:0]   h_pay;
    logic [47:0]   h_stamp;
    logic [31:0]   h_seq;
    logic [7:0]    h_alive;
    logic          take;
    logic          len_bad, full;
    logic [48:0]   due;
    logic [5:0]    flip;
    logic [63:0]   gen_next;
    logic [10:0]   fold_w, rem_w;
    t_rsp          take_rsp;

    assign {h_id, h_len, h_pay, h_stamp, h_seq, h_alive} = rdata;
    assign take = s_q.valid && r_state == BK_IDLE && !r_ovalid;
    assign s_q.ready = take;
    assign s_cfg.ready = 1'b1;
    assign m_out.valid = r_ovalid;
    assign m_out.data = r_rsp;
    assign len_bad = s_q.data.length_code > 4'(MAX_PAYLOAD_BYTES);
    assign full = r_held >= CW'(QUEUE_DEPTH);
    assign we = take && (s_q.data.op == OP_PUBLISH || s_q.data.op == OP_INJECT)
        && !len_bad && !full;
    assign due = {1'b0, h_stamp} + {17'd0, r_delay};
    assign flip = {r_lrem[2:0], r_draw[2:0]};
    assign gen_next = xorshift(r_gen);
    assign fold_w = 11'(14'(r_acc[23:10]) * 14'd24 + 14'(r_acc[9:0]));

    always_comb begin
        rem_w = fold_w;
        if (rem_w >= 11'd800) begin
            rem_w = rem_w - 11'd800;
        end
        if (rem_w >= 11'd400) begin
            rem_w = rem_w - 11'd400;
        end
        if (rem_w >= 11'd200) begin
            rem_w = rem_w - 11'd200;
        end
        if (rem_w >= 11'd100) begin
            rem_w = rem_w - 11'd100;
        end
    end

    always_comb begin
        if (s_q.data.op == OP_PUBLISH) begin
            wdata = {s_q.data.frame_id, s_q.data.length_code,
                     s_q.data.payload & byte_mask(s_q.data.length_code),
                     s_q.data.time_ms, r_nseq, r_nalive};
        end else begin
            wdata = {s_q.data.frame_id, s_q.data.length_code, s_q.data.payload,
                     s_q.data.time_ms, s_q.data.seq_in, s_q.data.alive_in};
        end
    end

    always_comb begin
        take_rsp = '0;
        take_rsp.fill_level = 5'(r_held);
        case (s_q.data.op)
            OP_PUBLISH, OP_INJECT: begin
                take_rsp.status = len_bad ? ST_RANGE : (full ? ST_FULL : ST_OK);
                take_rsp.fill_level = 5'(r_held + CW'(we));
            end
            OP_POLL: take_rsp.status = (r_held == '0) ? ST_EMPTY : ST_OK;
            default: take_rsp.status = ST_OK;
        endcase
    end

    ifc_ram #(.WIDTH(FW), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_wr),
        .i_wdata(wdata),
        .i_raddr(r_rd),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (take && s_q.data.op == OP_POLL && r_held != '0) begin
                    n_state = BK_DUE;
                end
            end
            BK_DUE: begin
                n_state = ({1'b0, r_now} < due) ? BK_DONE : BK_DRAW1;
            end
            BK_DRAW1: n_state = BK_MOD1;
            BK_MOD1: begin
                if (r_cnt == '0) begin
                    if (r_rem < r_loss || !r_tamper) begin
                        n_state = BK_DONE;
                    end else begin
                        n_state = BK_DRAW2;
                    end
                end
            end
            BK_DRAW2: n_state = BK_MOD2;
            BK_MOD2: begin
                if (r_cnt == '0) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd     <= '0;
            r_wr     <= '0;
            r_held   <= '0;
            r_gen    <= 64'd1;
            r_nseq   <= 32'd1;
            r_nalive <= '0;
            r_now    <= '0;
            r_loss   <= '0;
            r_delay  <= '0;
            r_tamper <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (s_cfg.valid) begin
                case (s_cfg.index)
                    CFG_LOSS:   r_loss <= s_cfg.wdata[6:0];
                    CFG_DELAY:  r_delay <= s_cfg.wdata[31:0];
                    CFG_TAMPER: r_tamper <= s_cfg.wdata[0];
                    CFG_SEED:   r_gen <= (s_cfg.wdata == '0) ? 64'd1 : s_cfg.wdata;
                    default: ;
                endcase
            end
            if (take && !(s_q.data.op == OP_POLL && r_held != '0)) begin
                r_ovalid <= 1'b1;
            end else if (r_state == BK_DONE) begin
                r_ovalid <= 1'b1;
            end else if (m_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (we) begin
                r_wr <= (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
                r_held <= r_held + 1'b1;
                if (s_q.data.op == OP_PUBLISH) begin
                    r_nseq <= r_nseq + 1'b1;
                    r_nalive <= r_nalive + 1'b1;
                end
            end
            if (take && s_q.data.op == OP_SETTIME) begin
                r_now <= s_q.data.time_ms;
            end
            if (r_state == BK_DUE && !({1'b0, r_now} < due)) begin
                r_rd <= (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
                r_held <= r_held - 1'b1;
            end
            if (r_state == BK_DRAW1 || r_state == BK_DRAW2) begin
                r_gen <= gen_next;
            end
        end
    end

    // draw % 100 by folding 2^k mod 100 terms, draw % length by serial restoring division
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_DRAW1: begin
                r_draw <= gen_next;
                r_cnt  <= 7'd4;
            end
            BK_DRAW2: begin
                r_draw <= gen_next;
                r_lrem <= '0;
                r_cnt  <= 7'd64;
            end
            BK_MOD1: begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                    case (r_cnt)
                        7'd4: r_acc <= 24'(r_draw[15:0]) + 24'(r_draw[31:16]) * 24'd36
                            + 24'(r_draw[47:32]) * 24'd96 + 24'(r_draw[63:48]) * 24'd56;
                        7'd3: r_acc <= 24'(r_acc[23:12]) * 24'd96 + 24'(r_acc[11:0]);
                        7'd2: r_acc <= 24'(r_acc[23:10]) * 24'd24 + 24'(r_acc[9:0]);
                        default: r_rem <= 7'(rem_w);
                    endcase
                end
            end
            BK_MOD2: begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                    r_draw <= {r_draw[62:0], r_draw[63]};
                    if ({r_lrem, r_draw[63]} >= {1'b0, r_rsp.out_length}) begin
                        r_lrem <= 4'({r_lrem, r_draw[63]} - {1'b0, r_rsp.out_length});
                    end else begin
                        r_lrem <= {r_lrem[2:0], r_draw[63]};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rsp <= take_rsp;
        end
        if (r_state == BK_DUE) begin
            if ({1'b0, r_now} < due) begin
                r_rsp.status <= ST_NOT_DUE;
            end else begin
                r_rsp.fill_level <= 5'(r_held - 1'b1);
                r_rsp.out_id <= h_id;
                r_rsp.out_length <= h_len;
                r_rsp.out_payload <= h_pay;
                r_rsp.out_stamp <= h_stamp;
                r_rsp.out_seq <= h_seq;
                r_rsp.out_alive <= h_alive;
            end
        end
        if (r_state == BK_MOD1 && r_cnt == '0 && r_rem < r_loss) begin
            r_rsp.status <= ST_DROPPED;
            r_rsp.out_id <= '0;
            r_rsp.out_length <= '0;
            r_rsp.out_payload <= '0;
            r_rsp.out_stamp <= '0;
            r_rsp.out_seq <= '0;
            r_rsp.out_alive <= '0;
        end
        if (r_state == BK_DRAW2) begin
            r_rsp.crc_invalid <= gen_next[0] && r_rsp.out_length != '0;
        end
        if (r_state == BK_MOD2 && r_cnt == '0 && r_rsp.crc_invalid) begin
            r_rsp.out_payload[flip] <= ~r_rsp.out_payload[flip];
        end
    end

    `IFC_ASSERT_IMPL(a_held_range, i_clk, i_rst_n, r_held <= CW'(QUEUE_DEPTH))
    `IFC_ASSERT_NEVER(a_take_busy, i_clk, i_rst_n, take && r_state != BK_IDLE)
    `IFC_ASSERT_IMPL(a_done_valid, i_clk, i_rst_n, r_state == BK_DONE |=> r_ovalid)
    `IFC_ASSERT_NEVER(a_we_poll, i_clk, i_rst_n, we && r_state != BK_IDLE)
endmodule
`default_nettype wire

// File: rtl/impaired_frame_channel_unit.sv
// top level of the impaired frame channel
// publish, inject, set time and an empty poll are answered from the take; a poll not yet due
// after the due check, a due poll after the loss draw and, if kept with tampering on, the tamper draw
// the loss draw folds its draw to a remainder by 100, the tamper draw takes a remainder by length
// one item at a time in the back end, none taken while a result waits; the front stage holds the next
// synchronous active-low reset empties the queue and restores the control and configuration registers
`default_nettype none
module impaired_frame_channel_unit import ifc_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
    parameter int unsigned MAX_PAYLOAD_BYTES = MaxPayloadDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ifc_req_if.sink   s_in,
    ifc_rsp_if.source m_out,
    ifc_cfg_if.sink   s_cfg
);
    ifc_req_if u_q ();

    ifc_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_in   (s_in),
        .m_q    (u_q.source)
    );

    ifc_back #(
        .QUEUE_DEPTH      (QUEUE_DEPTH),
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_q    (u_q.sink),
        .m_out  (m_out),
        .s_cfg  (s_cfg)
    );
endmodule
`default_nettype wire

// File: test/impaired_frame_channel_unit_test.sv
// testbench for the impaired frame channel: directed and random items checked against a predictor
`default_nettype none
module impaired_frame_channel_unit_test;
    import ifc_pkg::*;

    localparam int Depth = 16;
    localparam int MaxBytes = 8;

    typedef struct packed {
        logic [31:0] id;
        logic [3:0]  len;
        logic [63:0] pay;
        logic [47:0] stamp;
        logic [31:0] seq;
        logic [7:0]  alive;
    } t_frame;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    ifc_req_if in_ch ();
    ifc_rsp_if out_ch ();
    ifc_cfg_if cfg_ch ();

    impaired_frame_channel_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch),
        .m_out   (out_ch),
        .s_cfg   (cfg_ch)
    );

    t_frame      slots [Depth];
    int          head_slot, tail_slot, frames_queued;
    logic [63:0] draw_state;
    logic [31:0] seq_count;
    logic [7:0]  alive_count;
    logic [47:0] link_time;
    logic [6:0]  loss_pct;
    logic [31:0] link_delay;
    logic        tamper_en;

    t_rsp        pending_results [$];
    int          mismatches;
    int          send_idle, recv_stall, hold_off;
    logic [47:0] now_ms;

    function automatic logic [63:0] next_draw();
        draw_state = draw_state ^ (draw_state << 13);
        draw_state = draw_state ^ (draw_state >> 7);
        draw_state = draw_state ^ (draw_state << 17);
        return draw_state;
    endfunction

    function automatic t_rsp predict_result(input t_req q);
        t_rsp        r;
        t_frame      f;
        logic [63:0] d;
        logic [48:0] due;
        logic [63:0] keep;
        logic [6:0]  pos;
        r = '0;
        r.status = ST_OK;
        if (q.op == OP_PUBLISH || q.op == OP_INJECT) begin
            if (q.length_code > MaxBytes) begin
                r.status = ST_RANGE;
            end else if (frames_queued >= Depth) begin
                r.status = ST_FULL;
            end else begin
                f.id = q.frame_id;
                f.len = q.length_code;
                f.stamp = q.time_ms;
                if (q.op == OP_PUBLISH) begin
                    keep = (q.length_code >= 8) ? '1 : (64'd1 << (8 * q.length_code)) - 64'd1;
                    f.pay = q.payload & keep;
                    f.seq = seq_count;
                    f.alive = alive_count;
                    seq_count = seq_count + 32'd1;
                    alive_count = alive_count + 8'd1;
                end else begin
                    f.pay = q.payload;
                    f.seq = q.seq_in;
                    f.alive = q.alive_in;
                end
                slots[tail_slot] = f;
                tail_slot = (tail_slot + 1) % Depth;
                frames_queued++;
            end
        end else if (q.op == OP_SETTIME) begin
            link_time = q.time_ms;
        end else if (frames_queued == 0) begin
            r.status = ST_EMPTY;
        end else begin
            f = slots[head_slot];
            due = {1'b0, f.stamp} + {17'd0, link_delay};
            if ({1'b0, link_time} < due) begin
                r.status = ST_NOT_DUE;
            end else begin
                head_slot = (head_slot + 1) % Depth;
                frames_queued--;
                d = next_draw();
                if ((d % 64'd100) < {57'd0, loss_pct}) begin
                    r.status = ST_DROPPED;
                end else begin
                    r.out_id = f.id;
                    r.out_length = f.len;
                    r.out_payload = f.pay;
                    r.out_stamp = f.stamp;
                    r.out_seq = f.seq;
                    r.out_alive = f.alive;
                    if (tamper_en) begin
                        d = next_draw();
                        if (d[0] && f.len != 0) begin
                            pos = 7'((d % 64'(f.len)) * 8) + 7'(d[2:0]);
                            r.out_payload = r.out_payload ^ (64'd1 << pos[5:0]);
                            r.crc_invalid = 1'b1;
                        end
                    end
                end
            end
        end
        r.fill_level = 5'(frames_queued);
        return r;
    endfunction

    // result checking and receiver ready
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
            end else begin
                want = pending_results.pop_front();
                if (out_ch.data !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch expected %p", want);
                        $display("         actual   %p", out_ch.data);
                    end
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_item(input t_req q);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= q;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(predict_result(q));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [63:0] v);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_LOSS: loss_pct = v[6:0];
            CFG_DELAY: link_delay = v[31:0];
            CFG_TAMPER: tamper_en = v[0];
            CFG_SEED: draw_state = (v == 0) ? 64'd1 : v;
            default: ;
        endcase
    endtask

    function automatic t_req mk(input t_op op, input logic [31:0] id, input logic [3:0] len,
                                input logic [63:0] pay, input logic [47:0] tm,
                                input logic [31:0] seq, input logic [7:0] alive);
        t_req q;
        q.op = op;
        q.frame_id = id;
        q.length_code = len;
        q.payload = pay;
        q.time_ms = tm;
        q.seq_in = seq;
        q.alive_in = alive;
        return q;
    endfunction

    function automatic t_req random_item();
        t_req q;
        int   k;
        q = mk(OP_POLL, $urandom, 4'($urandom_range(8)), {$urandom, $urandom},
               now_ms - 48'($urandom_range(16)), $urandom, 8'($urandom));
        if ($urandom_range(9) == 0) q.length_code = 4'($urandom_range(15, 9));
        if ($urandom_range(30) == 0) q.time_ms = 48'({$urandom, $urandom});
        k = $urandom_range(99);
        if (k < 30) begin
            q.op = OP_PUBLISH;
        end else if (k < 50) begin
            q.op = OP_INJECT;
        end else if (k >= 85) begin
            q.op = OP_SETTIME;
            now_ms = ($urandom_range(40) == 0) ? 48'({$urandom, $urandom})
                                               : now_ms + 48'($urandom_range(40));
            q.time_ms = now_ms;
        end
        return q;
    endfunction

    task automatic test_directed();
        send_item(mk(OP_POLL, 0, 0, 0, 0, 0, 0));
        send_item(mk(OP_SETTIME, 0, 0, 0, 48'd100, 0, 0));
        send_item(mk(OP_PUBLISH, '1, 4'd0, '1, 48'd50, 0, 0));
        send_item(mk(OP_PUBLISH, 32'd7, 4'd3, '1, 48'd60, 0, 0));
        send_item(mk(OP_PUBLISH, 32'd8, 4'd8, '1, 48'd70, 0, 0));
        send_item(mk(OP_PUBLISH, 32'd9, 4'd9, '1, 48'd70, 0, 0));
        send_item(mk(OP_INJECT, 32'd10, 4'd15, '1, 48'd70, '1, '1));
        send_item(mk(OP_INJECT, 32'd11, 4'd8, 64'h8000_0000_0000_0001, '0, '1, '1));
        send_item(mk(OP_INJECT, 32'd12, 4'd2, '1, 48'd100, '0, '0));
        repeat (6) send_item(mk(OP_POLL, 0, 0, 0, 0, 0, 0));
        set_reg(CFG_DELAY, 64'd1000);
        send_item(mk(OP_PUBLISH, 32'd13, 4'd4, 64'h0123_4567_89ab_cdef, 48'd100, 0, 0));
        send_item(mk(OP_POLL, 0, 0, 0, 0, 0, 0));
        send_item(mk(OP_SETTIME, 0, 0, 0, 48'd1099, 0, 0));
        send_item(mk(OP_POLL, 0, 0, 0, 0, 0, 0));
        send_item(mk(OP_SETTIME, 0, 0, 0, '1, 0, 0));
        send_item(mk(OP_POLL, 0, 0, 0, 0, 0, 0));
        now_ms = 48'd0;
        send_item(mk(OP_SETTIME, 0, 0, 0, now_ms, 0, 0));
    endtask

    task automatic test_backpressure();
        set_reg(CFG_DELAY, 64'd0);
        set_reg(CFG_LOSS, 64'd0);
        send_idle = 0;
        recv_stall = 0;
        hold_off = 600;
        repeat (20) send_item(mk(OP_PUBLISH, $urandom, 4'($urandom_range(8)),
                                 {$urandom, $urandom}, now_ms, 0, 0));
        send_item(mk(OP_INJECT, 32'd1, 4'd9, '1, now_ms, 0, 0));
        wait_drained();
        repeat (18) send_item(mk(OP_POLL, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_phase(input int s_idle, input int r_stall, input logic [6:0] loss,
                                     input logic [31:0] delay, input logic tamper,
                                     input logic [63:0] seed, input int count);
        set_reg(CFG_LOSS, {57'd0, loss});
        set_reg(CFG_DELAY, {32'd0, delay});
        set_reg(CFG_TAMPER, {63'd0, tamper});
        set_reg(CFG_SEED, seed);
        send_idle = s_idle;
        recv_stall = r_stall;
        repeat (count) send_item(random_item());
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_LOSS;
        cfg_ch.wdata = '0;
        out_ch.ready = 1'b0;
        head_slot = 0;
        tail_slot = 0;
        frames_queued = 0;
        draw_state = 64'd1;
        seq_count = 32'd1;
        alive_count = 8'd0;
        link_time = '0;
        loss_pct = '0;
        link_delay = '0;
        tamper_en = 1'b0;
        mismatches = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_off = 0;
        now_ms = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_phase(0, 0, 7'd0, 32'd5, 1'b1, 64'd0, 260);
        test_random_phase(80, 0, 7'd127, 32'd0, 1'b0, '1, 60);
        test_random_phase(0, 80, 7'd100, '1, 1'b1, {$urandom, $urandom}, 60);
        test_random_phase(0, 80, 7'd30, 32'd3, 1'b1, {$urandom, $urandom}, 250);
        test_random_phase(13, 13, 7'd50, 32'd0, 1'b0, {$urandom, $urandom}, 250);
        test_random_phase(13, 13, 7'd10, 32'd10, 1'b1, {$urandom, $urandom}, 200);
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
+incdir+rtl
rtl/ifc_pkg.sv
rtl/ifc_if.sv
rtl/ifc_ram.sv
rtl/ifc_front.sv
rtl/ifc_back.sv
rtl/impaired_frame_channel_unit.sv
test/impaired_frame_channel_unit_test.sv
